FILE: rtl/bphcf_pkg.sv
// Shared types, constants and the CRC byte update for the packet header CRC framer.
package bphcf_pkg;

   // Payload limit and CRC-16/MODBUS constants
   localparam int unsigned MAX_PAYLOAD = 253;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [7:0]  ROUTE_MASK  = 8'h7F;
   localparam logic [7:0]  LEN_EXTRA   = 8'd2;

   // Command codes
   localparam logic CMD_PAYLOAD = 1'b0;
   localparam logic CMD_FINISH  = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   // Queue between front and back (depth must be a power of two)
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic        cmd;
      logic [7:0]  data_byte;
      logic [2:0]  packet_type;
      logic        priority_flag;
      logic        address_flag;
      logic        src_segment_flag;
      logic        dst_segment_flag;
      logic [1:0]  version;
      logic [2:0]  crypt_mode;
      logic [7:0]  route;
      logic [15:0] src_address;
      logic [15:0] dst_address;
   } req_type;

   typedef struct packed {
      logic [63:0] header_bytes;
      logic [3:0]  header_length;
      logic [15:0] crc_value;
      logic [7:0]  length_byte;
      logic [1:0]  status;
   } rsp_type;

   // Classified beat as held in the queue
   typedef struct packed {
      logic        is_finish;
      logic [7:0]  data_byte;
      logic [7:0]  marker;
      logic [7:0]  flags;
      logic        route_f;
      logic        src_f;
      logic        dst_f;
      logic        addr_f;
      logic [7:0]  route;
      logic [15:0] src_address;
      logic [15:0] dst_address;
   } entry_type;

   // One byte through the reflected CRC-16/MODBUS polynomial
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/bphcf_front.sv
// Front part: classifies each accepted beat and forms the marker and flag bytes.
module bphcf_front (
   input  bphcf_pkg::req_type   req_payload,
   output bphcf_pkg::entry_type entry
);

   logic route_f;

   // Route byte is present when its low seven bits are nonzero
   assign route_f = (req_payload.route & bphcf_pkg::ROUTE_MASK) != 8'h00;

   // Build the queue entry
   always_comb begin
      entry.is_finish   = (req_payload.cmd == bphcf_pkg::CMD_FINISH);
      entry.data_byte   = req_payload.data_byte;
      entry.marker      = {req_payload.priority_flag, 3'b000, req_payload.address_flag,
                           req_payload.packet_type};
      entry.flags       = {route_f, req_payload.src_segment_flag,
                           req_payload.dst_segment_flag, req_payload.version,
                           req_payload.crypt_mode};
      entry.route_f     = route_f;
      entry.src_f       = req_payload.src_segment_flag;
      entry.dst_f       = req_payload.dst_segment_flag;
      entry.addr_f      = req_payload.address_flag;
      entry.route       = req_payload.route;
      entry.src_address = req_payload.src_address;
      entry.dst_address = req_payload.dst_address;
   end

endmodule

FILE: rtl/bphcf_queue.sv
// Short queue of classified beats between the front and back parts.
module bphcf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bphcf_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output bphcf_pkg::entry_type head_entry
);

   bphcf_pkg::entry_type                     store_ff [bphcf_pkg::QUEUE_DEPTH];
   logic [bphcf_pkg::QUEUE_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [bphcf_pkg::QUEUE_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [bphcf_pkg::QUEUE_CNT_W-1:0]        count_ff, count_in;
   logic                                     do_push, do_pop;

   assign full       = (count_ff == bphcf_pkg::QUEUE_CNT_W'(bphcf_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/bphcf_back.sv
// Back part: runs the CRC and byte count, assembles the header and holds the result beat.
module bphcf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  bphcf_pkg::entry_type head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bphcf_pkg::rsp_type   rsp_payload
);

   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bphcf_pkg::rsp_type rsp_ff, rsp_in;

   logic               out_free;
   logic               take_finish;
   logic [7:0]         len_byte;
   logic [7:0]         hb [8];
   logic [3:0]         pos;
   logic [63:0]        hdr;
   bphcf_pkg::rsp_type frame;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pop         = head_valid && (!head_entry.is_finish || out_free);
   assign take_finish = pop && head_entry.is_finish;
   assign len_byte    = count_ff + bphcf_pkg::LEN_EXTRA;

   // Assemble header bytes in order, optional bytes closing up the gaps
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         hb[i] = 8'h00;
      end
      hb[0] = head_entry.marker;
      hb[1] = head_entry.flags;
      hb[2] = len_byte;
      pos   = 4'd3;
      if (head_entry.route_f) begin
         hb[pos[2:0]] = head_entry.route;
         pos = pos + 4'd1;
      end
      if (head_entry.src_f) begin
         hb[pos[2:0]] = head_entry.src_address[15:8];
         pos = pos + 4'd1;
      end
      hb[pos[2:0]] = head_entry.src_address[7:0];
      pos = pos + 4'd1;
      if (head_entry.dst_f) begin
         hb[pos[2:0]] = head_entry.dst_address[15:8];
         pos = pos + 4'd1;
      end
      if (head_entry.addr_f) begin
         hb[pos[2:0]] = head_entry.dst_address[7:0];
         pos = pos + 4'd1;
      end
      for (int i = 0; i < 8; i++) begin
         hdr[8*i +: 8] = hb[i];
      end
   end

   // Form the result beat, an empty payload giving a zeroed frame
   always_comb begin
      if (count_ff == 8'd0) begin
         frame.header_bytes  = '0;
         frame.header_length = '0;
         frame.crc_value     = '0;
         frame.length_byte   = '0;
         frame.status        = bphcf_pkg::STATUS_EMPTY;
      end else begin
         frame.header_bytes  = hdr;
         frame.header_length = pos;
         frame.crc_value     = crc_ff;
         frame.length_byte   = len_byte;
         frame.status        = ovf_ff ? bphcf_pkg::STATUS_TOO_LONG : bphcf_pkg::STATUS_OK;
      end
   end

   // Update packet state: absorb payload beats up to the limit, flag overflow beyond it, rearm on finish
   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (pop) begin
         if (head_entry.is_finish) begin
            crc_in   = bphcf_pkg::CRC_INIT;
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (count_ff < 8'(bphcf_pkg::MAX_PAYLOAD)) begin
            crc_in   = bphcf_pkg::crc_byte(crc_ff, head_entry.data_byte);
            count_in = count_ff + 8'd1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // Load or drain the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (take_finish) begin
         rsp_valid_in = 1'b1;
         rsp_in       = frame;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= bphcf_pkg::CRC_INIT;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/bus_packet_header_crc_framer_unit.sv
// A finish beat accepted into the queue waits at its head until the output register is free,
// then loads it; the result is offered from that register until it is taken.
// Throughput: one beat per cycle unless stalled; back-part CRC byte update is combinational.
// A two-entry queue lets the front keep accepting while a result waits on rsp_stall.
// Reset (synchronous, active high) empties the queue and output register and sets the CRC
// to 0xFFFF with a zero byte count.
module bus_packet_header_crc_framer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bphcf_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bphcf_pkg::rsp_type rsp_payload
);

   bphcf_pkg::entry_type entry;
   bphcf_pkg::entry_type head_entry;
   logic                 full;
   logic                 head_valid;
   logic                 pop;

   // Classify incoming beats
   bphcf_front u_front (
      .req_payload (req_payload),
      .entry       (entry)
   );

   // Decouple front and back
   bphcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_entry (entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   assign req_stall = full;

   // Carry out CRC, count and framing
   bphcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/bphcf_checker.sv
// Port-level checks on the framer's result channel, bound to the top level.
module bphcf_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input bphcf_pkg::rsp_type rsp_payload
);

   // A stalled result beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Status is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == bphcf_pkg::STATUS_OK ||
                     rsp_payload.status == bphcf_pkg::STATUS_EMPTY ||
                     rsp_payload.status == bphcf_pkg::STATUS_TOO_LONG))
      else $error("undefined status code");

   // An empty packet gives an all-zero frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == bphcf_pkg::STATUS_EMPTY |->
         rsp_payload.header_bytes == '0 && rsp_payload.header_length == '0 &&
         rsp_payload.crc_value == '0 && rsp_payload.length_byte == '0)
      else $error("empty packet frame not zeroed");

   // A real frame has 4 to 8 header bytes and carries the length byte third
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != bphcf_pkg::STATUS_EMPTY |->
         rsp_payload.header_length >= 4'd4 && rsp_payload.header_length <= 4'd8 &&
         rsp_payload.header_bytes[23:16] == rsp_payload.length_byte &&
         rsp_payload.length_byte >= 8'd3)
      else $error("malformed header in result beat");

endmodule

bind bus_packet_header_crc_framer_unit bphcf_checker u_bphcf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
